// ===== rtl/ktk_pkg.sv =====
// Package for the keyed top-k table: request codes, widths, defaults.
package ktk_pkg;
  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned ValW = 31;
  localparam int unsigned RankW = 5;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_DRAIN  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;
endpackage

// ===== rtl/keyed_top_k_table_top.sv =====
// Keyed top-k table: update scans the memory one entry per cycle; drain sorts by selection.
// Clear: applied at the accepting edge, busy does not rise. Update: a match scan, then a min
// scan on a full table, then a write. Drain: each pass scans for the best unsorted entry,
// shifts the unsorted entries before it up by one, writes it into place and strobes it out.
// One request at a time; results cannot be stalled. Synchronous reset empties the table;
// entry memories are not cleared.
module keyed_top_k_table_top
  import ktk_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [ValW-1:0]     player_key,
  input  logic [ValW-1:0]     score,
  input  logic [ValW-1:0]     tiebreak,
  output logic                strobe,
  output logic [RankW-1:0]    rank,
  output logic [ValW-1:0]     entry_key,
  output logic [ValW-1:0]     entry_score,
  output logic [ValW-1:0]     entry_tiebreak,
  output logic                last
);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EntW = 3 * ValW;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MATCH  = 8'b00000010,
    S_MIN    = 8'b00000100,
    S_REPL   = 8'b00001000,
    S_SCAN   = 8'b00010000,
    S_SHIFTR = 8'b00100000,
    S_SHIFTW = 8'b01000000,
    S_EMIT   = 8'b10000000
  } state_t;

  logic [EntW-1:0] mem [MAX_ENTRIES];
  logic [EntW-1:0] rd_data;
  logic [IdxW-1:0] rd_addr;
  logic            rd_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;
  logic            wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  state_t          state;
  logic [CntW-1:0] used_count;
  logic [ValW-1:0] k_in, s_in, t_in;
  logic [CntW-1:0] cnt;       // next index to issue
  logic            pend;      // a read is in flight
  logic [IdxW-1:0] pidx;      // index of the in-flight read
  logic [CntW-1:0] pos;       // drain position being filled
  logic [IdxW-1:0] best_idx;
  logic [EntW-1:0] best;
  logic [IdxW-1:0] sidx;      // slot being refilled during the shift

  logic [ValW-1:0] rk, rs, rt, bs, bt;
  assign rk = rd_data[EntW-1 -: ValW];
  assign rs = rd_data[2*ValW-1 -: ValW];
  assign rt = rd_data[ValW-1:0];
  assign bs = best[2*ValW-1 -: ValW];
  assign bt = best[ValW-1:0];

  logic better;
  assign better = (rs > bs) || ((rs == bs) && (rt > bt));

  logic issue;
  assign issue = (cnt < used_count);

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = pidx;
    wr_data = rd_data;
    unique case (state)
      S_MATCH: begin
        rd_en = issue;
        if (!issue && !pend && used_count < CntW'(MAX_ENTRIES)) begin
          wr_en   = 1'b1;
          wr_addr = used_count[IdxW-1:0];
          wr_data = {k_in, s_in, t_in};
        end
      end
      S_MIN, S_SCAN: rd_en = issue;
      S_SHIFTR: begin
        rd_en   = 1'b1;
        rd_addr = sidx - IdxW'(1);
      end
      S_REPL: begin
        wr_en   = (s_in > bs);
        wr_addr = best_idx;
        wr_data = {k_in, s_in, t_in};
      end
      S_SHIFTW: begin
        wr_en   = 1'b1;
        wr_addr = sidx;
        wr_data = rd_data;
      end
      S_EMIT: begin
        wr_en   = 1'b1;
        wr_addr = pos[IdxW-1:0];
        wr_data = best;
      end
      default: ;
    endcase
    if (state == S_MATCH && pend && rk == k_in) begin
      wr_en   = (s_in > rs);
      wr_addr = pidx;
      wr_data = {rk, s_in, rt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      pend       <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      pend   <= rd_en;
      pidx   <= rd_addr;
      if (rd_en) cnt <= cnt + CntW'(1);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k_in <= player_key;
            s_in <= score;
            t_in <= tiebreak;
            cnt  <= '0;
            pend <= 1'b0;
            pos  <= '0;
            unique case (req_type)
              REQ_CLEAR:  used_count <= '0;
              REQ_UPDATE: state <= S_MATCH;
              REQ_DRAIN:  if (used_count != '0) state <= S_SCAN;
              default: ;
            endcase
          end
        end
        S_MATCH: begin
          if (pend && rk == k_in) begin
            state <= S_IDLE;
          end else if (!issue && !pend) begin
            if (used_count < CntW'(MAX_ENTRIES)) begin
              used_count <= used_count + CntW'(1);
              state      <= S_IDLE;
            end else begin
              cnt   <= '0;
              state <= S_MIN;
            end
          end
        end
        S_MIN: begin
          if (pend && (pidx == '0 || rs < bs)) begin
            best     <= rd_data;
            best_idx <= pidx;
          end
          if (!issue && !pend) state <= S_REPL;
        end
        S_REPL: state <= S_IDLE;
        S_SCAN: begin
          if (pend && (pidx == pos[IdxW-1:0] || better)) begin
            best     <= rd_data;
            best_idx <= pidx;
          end
          if (!issue && !pend) begin
            sidx  <= best_idx;
            state <= (best_idx == pos[IdxW-1:0]) ? S_EMIT : S_SHIFTR;
          end
        end
        S_SHIFTR: state <= S_SHIFTW;
        // move the entries between pos and the winner up by one, keeping their order
        S_SHIFTW: begin
          sidx  <= sidx - IdxW'(1);
          state <= (sidx - IdxW'(1) == pos[IdxW-1:0]) ? S_EMIT : S_SHIFTR;
        end
        S_EMIT: begin
          strobe         <= 1'b1;
          rank           <= RankW'(pos + CntW'(1));
          entry_key      <= best[EntW-1 -: ValW];
          entry_score    <= bs;
          entry_tiebreak <= bt;
          last           <= (pos + CntW'(1) == used_count);
          if (pos + CntW'(1) == used_count) begin
            state <= S_IDLE;
          end else begin
            pos   <= pos + CntW'(1);
            cnt   <= pos + CntW'(1);
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the keyed top-k table: queue-fed driver, predictor and monitor.
`timescale 1ns / 100ps

module tb_top;
  import ktk_pkg::*;

  localparam int unsigned Slots = MaxEntriesDefault;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    req_t            req;
    logic [ValW-1:0] key;
    logic [ValW-1:0] sc;
    logic [ValW-1:0] tb;
  } request_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [ValW-1:0]  key;
    logic [ValW-1:0]  sc;
    logic [ValW-1:0]  tb;
    logic             last;
  } ranked_entry_t;

  logic clk, rst, start, busy, strobe, last;
  logic [1:0] req_type;
  logic [ValW-1:0] player_key, score, tiebreak, entry_key, entry_score, entry_tiebreak;
  logic [RankW-1:0] rank;

  keyed_top_k_table_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .player_key(player_key), .score(score), .tiebreak(tiebreak), .strobe(strobe),
    .rank(rank), .entry_key(entry_key), .entry_score(entry_score),
    .entry_tiebreak(entry_tiebreak), .last(last)
  );

  request_t      pending_reqs[$];
  ranked_entry_t expected_ranks[$];
  int            mismatches = 0;
  int unsigned   cycles = 0;
  bit            stim_done = 0;

  // shadow table
  logic [ValW-1:0] tbl_key[Slots], tbl_score[Slots], tbl_tb[Slots];
  int unsigned     tbl_used = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [ValW-1:0] got,
                        input logic [ValW-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic bit outranks(input int a, input int b);
    if (tbl_score[a] != tbl_score[b]) return tbl_score[a] > tbl_score[b];
    return tbl_tb[a] > tbl_tb[b];
  endfunction

  task automatic apply_request(input request_t r);
    int order[Slots];
    logic [ValW-1:0] k[Slots], s[Slots], t[Slots];
    int j, low;
    ranked_entry_t e;
    case (r.req)
      REQ_CLEAR: tbl_used = 0;
      REQ_UPDATE: begin
        for (int i = 0; i < tbl_used; i++)
          if (tbl_key[i] == r.key) begin
            if (r.sc > tbl_score[i]) tbl_score[i] = r.sc;
            return;
          end
        if (tbl_used < Slots) begin
          tbl_key[tbl_used] = r.key; tbl_score[tbl_used] = r.sc; tbl_tb[tbl_used] = r.tb;
          tbl_used++;
          return;
        end
        low = 0;
        for (int i = 1; i < Slots; i++) if (tbl_score[i] < tbl_score[low]) low = i;
        if (r.sc > tbl_score[low]) begin
          tbl_key[low] = r.key; tbl_score[low] = r.sc; tbl_tb[low] = r.tb;
        end
      end
      REQ_DRAIN: begin
        // stable insertion sort: equal entries keep index order
        for (int i = 0; i < tbl_used; i++) begin
          j = i;
          while (j > 0 && outranks(i, order[j-1])) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = i;
        end
        for (int i = 0; i < tbl_used; i++) begin
          k[i] = tbl_key[order[i]]; s[i] = tbl_score[order[i]]; t[i] = tbl_tb[order[i]];
        end
        for (int i = 0; i < tbl_used; i++) begin
          tbl_key[i] = k[i]; tbl_score[i] = s[i]; tbl_tb[i] = t[i];
          e.rank = RankW'(i + 1); e.key = k[i]; e.sc = s[i]; e.tb = t[i];
          e.last = (i + 1 == tbl_used);
          expected_ranks.push_back(e);
        end
      end
      default: ;
    endcase
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    ranked_entry_t w;
    request_t r;
    cycles <= cycles + 1;
    if (!rst) begin
      if (strobe) begin
        if (expected_ranks.size() == 0) begin
          $display("unexpected word at cycle %0d, rank %0d", cycles, rank);
          mismatches++;
        end else begin
          w = expected_ranks.pop_front();
          if (rank !== w.rank) report("rank", ValW'(rank), ValW'(w.rank));
          if (entry_key !== w.key) report("entry_key", entry_key, w.key);
          if (entry_score !== w.sc) report("entry_score", entry_score, w.sc);
          if (entry_tiebreak !== w.tb) report("entry_tiebreak", entry_tiebreak, w.tb);
          if (last !== w.last) report("last", ValW'(last), ValW'(w.last));
        end
      end
      if (start && !busy) begin
        r = '{req_t'(req_type), player_key, score, tiebreak};
        apply_request(r);
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return int'($urandom_range(1, 3));
      default:       return int'($urandom_range(10, 40));
    endcase
  endfunction

  // set when the word on the inputs was taken at the last rising edge
  bit taken = 0;
  always @(posedge clk) begin
    taken <= !rst && start && !busy;
  end

  // driver
  int gap = 0;
  always @(negedge clk) begin
    request_t r;
    int g;
    g = gap;
    if (start && taken) g = draw_gap();
    if (rst) begin
      start <= 0;
      gap <= 0;
    end else if (start && !taken) begin
      // hold the word until taken
    end else if (g > 0) begin
      gap <= g - 1;
      start <= 0;
      req_type <= 2'($urandom); player_key <= ValW'($urandom);
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      gap <= 0;
      start <= 1;
      req_type <= r.req; player_key <= r.key; score <= r.sc; tiebreak <= r.tb;
    end else begin
      gap <= 0;
      start <= 0;
    end
  end

  function automatic request_t mk(input req_t q, input logic [ValW-1:0] k,
                                  input logic [ValW-1:0] s, input logic [ValW-1:0] t);
    return '{q, k, s, t};
  endfunction

  function automatic logic [ValW-1:0] rnd_val(input int spread);
    case (spread)
      0: return ValW'($urandom_range(0, 7));
      1: return ValW'($urandom_range(0, 200));
      default: return ValW'($urandom);
    endcase
  endfunction

  initial begin
    int n, spread, pool;
    logic [ValW-1:0] kbase;
    rst = 1; start = 0; req_type = REQ_NONE;
    player_key = 0; score = 0; tiebreak = 0;

    // directed part
    pending_reqs.push_back(mk(REQ_DRAIN, 0, 0, 0));  // empty table
    pending_reqs.push_back(mk(REQ_UPDATE, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_UPDATE, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, 0, 5, 9));  // existing key raised, tiebreak kept
    pending_reqs.push_back(mk(REQ_UPDATE, 0, 2, 9));  // lower offer ignored
    pending_reqs.push_back(mk(REQ_NONE, 7, 7, 7));
    pending_reqs.push_back(mk(REQ_DRAIN, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 0));
    for (int i = 0; i < Slots; i++)  // equal scores, some equal tiebreaks
      pending_reqs.push_back(mk(REQ_UPDATE, ValW'(100 + i), 10, ValW'(i % 3)));
    pending_reqs.push_back(mk(REQ_UPDATE, 200, 10, 5));  // full, equal to lowest: ignored
    pending_reqs.push_back(mk(REQ_UPDATE, 201, 11, 5));  // replaces first lowest
    pending_reqs.push_back(mk(REQ_DRAIN, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, 202, 12, 0));  // replacement in sorted table
    pending_reqs.push_back(mk(REQ_DRAIN, 0, 0, 0));

    // random part: well-formed fill-then-drain runs, with some noise
    n = 0;
    while (n < 70) begin
      spread = $urandom_range(0, 2);
      pool = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(4, 24);
      kbase = ValW'($urandom);
      if ($urandom_range(0, 2) != 0) begin
        pending_reqs.push_back(mk(REQ_CLEAR, rnd_val(2), rnd_val(2), rnd_val(2)));
        n++;
      end
      repeat ($urandom_range(1, 24)) begin
        pending_reqs.push_back(mk(REQ_UPDATE,
          pool == 0 ? rnd_val(2) : kbase + ValW'($urandom_range(0, pool - 1)),
          rnd_val(spread), rnd_val($urandom_range(0, 2))));
        n++;
        if ($urandom_range(0, 15) == 0) begin
          pending_reqs.push_back(mk(REQ_DRAIN, rnd_val(2), rnd_val(2), rnd_val(2)));
          n++;
        end
        if ($urandom_range(0, 19) == 0) begin
          pending_reqs.push_back(mk(REQ_NONE, rnd_val(2), rnd_val(2), rnd_val(2)));
        end
      end
      pending_reqs.push_back(mk(REQ_DRAIN, rnd_val(2), rnd_val(2), rnd_val(2)));
      n++;
    end

    repeat (10) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() == 0);
    @(negedge clk);
    wait (!start && !busy && expected_ranks.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_ranks.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout, %0d words still expected", expected_ranks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
rtl/ktk_pkg.sv
rtl/keyed_top_k_table_top.sv
tb/tb_top.sv
